[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// Depends on nothing; included by file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset disables the check.
`define CRFS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crfs assertion failed");

// Next-cycle implication, reset disables the check.
`define CRFS_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crfs assertion failed");

`endif

[rtl/core/crfs_pkg.sv]
// Types, constants and the exp table generator of the cloud region scaling unit.
// Depends on nothing; used by the top level.
`timescale 1ns / 1ps
package crfs_pkg;

   // Fixed-point constants.
   localparam logic [15:0] ONE_Q15      = 16'd32768;
   localparam logic [15:0] ONE_Q12      = 16'd4096;
   localparam logic [15:0] FSD_SHARE_LO = 16'd6144;
   localparam logic [15:0] SHARE_MIN    = 16'd32768;
   localparam logic [15:0] SHARE_MAX    = 16'd58982;
   localparam logic [15:0] SAT_SCALING  = 16'hFFFF;
   // At or above this deviation offset the thin share is clamped at its maximum.
   localparam logic [15:0] SHARE_SAT_D  = 16'd9114;
   // Reciprocal of 89 at 2^29, exact for numerators below 2^22.
   localparam logic [22:0] RECIP_89     = 23'd6032258;
   localparam int          RECIP_89_SH  = 29;
   // Reciprocal of 5 at 2^18, exact for 16-bit values.
   localparam logic [15:0] RECIP_5      = 16'd52429;
   localparam int          RECIP_5_SH   = 18;

   // Divider: quotient bits resolved per pipeline stage.
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = 16 / DIV_STEPS;

   // Register indexes of the configuration port.
   localparam logic CSR_THREE_REGIONS   = 1'b0;
   localparam logic CSR_CLOUD_THRESHOLD = 1'b1;

   // How a level is treated.
   typedef enum logic [1:0] {
      CLS_TWO   = 2'd0,
      CLS_CLEAR = 2'd1,
      CLS_SPLIT = 2'd2
   } cls_type;

   // Shift-and-subtract quotient of a 64-bit value by a small series index.
   function automatic longint unsigned div_small(input longint unsigned n,
                                                 input int unsigned d);
      longint unsigned q;
      longint unsigned rem;
      q   = 64'd0;
      rem = 64'd0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], n[b]};
         q   = {q[62:0], 1'b0};
         if (rem >= 64'(d)) begin
            rem  = rem - 64'(d);
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   // exp(-r) in Q0.32 for r in Q.24 between 0 and 1, alternating series.
   function automatic longint unsigned exp_series(input longint unsigned r);
      longint unsigned term;
      longint unsigned pos;
      longint unsigned neg;
      term = 64'h1_0000_0000;
      pos  = 64'h1_0000_0000;
      neg  = 64'd0;
      for (int k = 1; k <= 20; k++) begin
         term = div_small((term * r) >> 24, k);
         if ((k & 1) == 1) neg = neg + term;
         else pos = pos + term;
      end
      return (pos > neg) ? pos - neg : 64'd0;
   endfunction

   // exp(-x) in Q0.32 for x in Q.24.
   function automatic longint unsigned exp_neg(input longint unsigned x);
      longint unsigned n;
      longint unsigned res;
      longint unsigned e1;
      n = x >> 24;
      if (n >= 64'd12) return 64'd0;
      res = exp_series(x & 64'h00FF_FFFF);
      e1  = exp_series(64'h0100_0000);
      for (longint unsigned i = 0; i < n; i++) res = (res * e1) >> 32;
      return res;
   endfunction

   // Table entry: exp of minus the cubic in the raw Q4.12 deviation, Q0.16.
   function automatic logic [16:0] exp_entry(input longint unsigned f);
      longint unsigned p;
      p = f * 64'd4096 + ((f * f) >> 1) + ((f * f * f) >> 14);
      return 17'((exp_neg(p) + 64'd32768) >> 16);
   endfunction

endpackage

[rtl/core/crfs_if.sv]
// Valid/ready channel interfaces for the level items and the result items.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
interface crfs_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] cloud_cover;
   logic [15:0] depth_spread;
   logic        last_level;

   modport source (output valid, cloud_cover, depth_spread, last_level, input ready);
   modport sink   (input valid, cloud_cover, depth_spread, last_level, output ready);
endinterface

interface crfs_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] clear_fraction;
   logic [15:0] thin_fraction;
   logic [15:0] thick_fraction;
   logic [15:0] thin_scaling;
   logic [15:0] thick_scaling;
   logic        last_out;

   modport source (output valid, clear_fraction, thin_fraction, thick_fraction,
                   thin_scaling, thick_scaling, last_out, input ready);
   modport sink   (input valid, clear_fraction, thin_fraction, thick_fraction,
                   thin_scaling, thick_scaling, last_out, output ready);
endinterface

[rtl/core/cloud_region_fraction_scaling_unit.sv]
// Cloud region fractions and optical-depth scalings, one level per transfer.
// Depends on crfs_pkg and the channel interfaces in crfs_if.sv.
//
//   channel  direction  handshake          payload
//   req      in         valid / ready      cloud_cover, depth_spread, last_level
//   rsp      out        valid / ready      three fractions, two scalings, last_out
//   csr      in         csr_wr_en only     csr_index, csr_wdata
//
// One level enters per cycle unless a stalled result on rsp holds the pipeline.
// Each level passes seven front stages, then the 16-bit restoring divider
// for the thick scaling, two quotient bits per stage over eight stages.
// Reset is synchronous; it clears the valid bits and loads the configuration
// registers with their reset values. The data registers are not reset.
// A stall on rsp freezes the whole pipeline; nothing is lost or repeated.
`timescale 1ns / 1ps
module cloud_region_fraction_scaling_unit
   import crfs_pkg::*;
#(
   parameter int EXP_TABLE_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   crfs_req_if.sink    req_chan,
   crfs_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int TABLE_LEN = (1 << EXP_TABLE_BITS) + 1;
   localparam int SH        = 16 - EXP_TABLE_BITS;
   localparam int IDX_W     = EXP_TABLE_BITS + 1;
   localparam int PW        = 17 + SH + 1;

   // Exp table, built at elaboration.
   logic [16:0] exp_tbl [TABLE_LEN];
   for (genvar k = 0; k < TABLE_LEN; k++) begin : g_tbl
      assign exp_tbl[k] = exp_entry(64'(k) << SH);
   end

   // Configuration registers.
   logic        three_ff;
   logic [15:0] thr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         three_ff <= 1'b1;
         thr_ff   <= 16'd1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_THREE_REGIONS:   three_ff <= csr_wdata[0];
            CSR_CLOUD_THRESHOLD: thr_ff   <= csr_wdata;
            default:             three_ff <= three_ff;
         endcase
      end
   end

   // Global advance: the pipeline moves unless the output holds a stalled result.
   logic vout_ff;
   logic en;
   assign en = !vout_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // Stage 1: saturate, classify, share numerator, table address.
   logic                  v1_ff;
   cls_type               cls1_ff, cls1_in;
   logic [15:0]           cf1_ff, cf1_in;
   logic                  last1_ff;
   logic [21:0]           shn1_ff, shn1_in;
   logic                  shsat1_ff, shsat1_in;
   logic [EXP_TABLE_BITS-1:0] idx1_ff;
   logic [SH-1:0]         fr1_ff;
   logic [15:0]           dev;

   always_comb begin
      cf1_in = (req_chan.cloud_cover > ONE_Q15) ? ONE_Q15 : req_chan.cloud_cover;
      if (!three_ff) cls1_in = CLS_TWO;
      else if (cf1_in < thr_ff) cls1_in = CLS_CLEAR;
      else cls1_in = CLS_SPLIT;
      dev       = req_chan.depth_spread - FSD_SHARE_LO;
      shsat1_in = (req_chan.depth_spread > FSD_SHARE_LO) && (dev >= SHARE_SAT_D);
      if ((req_chan.depth_spread > FSD_SHARE_LO) && !shsat1_in)
         shn1_in = {dev[13:0], 8'd0} + 22'd44;
      else
         shn1_in = 22'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= req_chan.valid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         cls1_ff   <= cls1_in;
         cf1_ff    <= cf1_in;
         last1_ff  <= req_chan.last_level;
         shn1_ff   <= shn1_in;
         shsat1_ff <= shsat1_in;
         idx1_ff   <= req_chan.depth_spread[15:SH];
         fr1_ff    <= req_chan.depth_spread[SH-1:0];
      end
   end

   // Stage 2: share by reciprocal of 89, table reads.
   logic        v2_ff;
   cls_type     cls2_ff;
   logic [15:0] cf2_ff;
   logic        last2_ff;
   logic [15:0] share2_ff, share2_in;
   logic [16:0] t0_2_ff, t1_2_ff;
   logic [SH-1:0] fr2_ff;
   logic [44:0] shprod;
   logic [IDX_W-1:0] idx_a, idx_b;

   always_comb begin
      shprod    = 45'(shn1_ff) * 45'(RECIP_89);
      share2_in = shsat1_ff ? SHARE_MAX : SHARE_MIN + 16'(shprod >> RECIP_89_SH);
      idx_a     = {1'b0, idx1_ff};
      idx_b     = idx_a + IDX_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         cls2_ff   <= cls1_ff;
         cf2_ff    <= cf1_ff;
         last2_ff  <= last1_ff;
         share2_ff <= share2_in;
         t0_2_ff   <= exp_tbl[idx_a];
         t1_2_ff   <= exp_tbl[idx_b];
         fr2_ff    <= fr1_ff;
      end
   end

   // Stage 3: interpolation products.
   logic          v3_ff;
   cls_type       cls3_ff;
   logic [15:0]   cf3_ff;
   logic          last3_ff;
   logic [15:0]   share3_ff;
   logic [PW-1:0] p0_3_ff, p1_3_ff;
   logic [SH:0]   w0;

   assign w0 = (SH+1)'(1 << SH) - {1'b0, fr2_ff};

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         cls3_ff   <= cls2_ff;
         cf3_ff    <= cf2_ff;
         last3_ff  <= last2_ff;
         share3_ff <= share2_ff;
         p0_3_ff   <= PW'(t0_2_ff) * PW'(w0);
         p1_3_ff   <= PW'(t1_2_ff) * PW'(fr2_ff);
      end
   end

   // Stage 4: thin fraction, rounded interpolated exp.
   logic        v4_ff;
   cls_type     cls4_ff;
   logic [15:0] cf4_ff;
   logic        last4_ff;
   logic [15:0] thin4_ff;
   logic [16:0] e4_ff;
   logic [31:0] thinprod;
   logic [PW-1:0] esum;

   always_comb begin
      thinprod = 32'(cf3_ff) * 32'(share3_ff);
      esum     = p0_3_ff + p1_3_ff + PW'(1 << (SH - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (en) v4_ff <= v3_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         cls4_ff  <= cls3_ff;
         cf4_ff   <= cf3_ff;
         last4_ff <= last3_ff;
         thin4_ff <= thinprod[31:16];
         e4_ff    <= 17'(esum >> SH);
      end
   end

   // Stage 5: thick fraction, scaled exp divided by 128.
   logic        v5_ff;
   cls_type     cls5_ff;
   logic [15:0] cf5_ff;
   logic        last5_ff;
   logic [15:0] thin5_ff, thick5_ff;
   logic [15:0] y5_ff;
   logic [22:0] ysum;

   assign ysum = 23'd65856 + 23'(e4_ff) * 23'd39;

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (en) v5_ff <= v4_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         cls5_ff   <= cls4_ff;
         cf5_ff    <= cf4_ff;
         last5_ff  <= last4_ff;
         thin5_ff  <= thin4_ff;
         thick5_ff <= cf4_ff - thin4_ff;
         y5_ff     <= 16'(ysum >> 7);
      end
   end

   // Stage 6: thin scaling, the remaining division by 5.
   logic        v6_ff;
   cls_type     cls6_ff;
   logic [15:0] cf6_ff;
   logic        last6_ff;
   logic [15:0] thin6_ff, thick6_ff, ts6_ff;
   logic [31:0] tsprod;

   assign tsprod = 32'(y5_ff) * 32'(RECIP_5);

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else if (en) v6_ff <= v5_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         cls6_ff   <= cls5_ff;
         cf6_ff    <= cf5_ff;
         last6_ff  <= last5_ff;
         thin6_ff  <= thin5_ff;
         thick6_ff <= thick5_ff;
         ts6_ff    <= 16'(tsprod >> RECIP_5_SH);
      end
   end

   // Divider pipeline. Entry 0 holds the rounded dividend split into a high
   // remainder and low bits; each later entry resolves DIV_STEPS quotient bits.
   logic        dv_v     [DIV_STAGES+1];
   cls_type     dv_cls   [DIV_STAGES+1];
   logic [15:0] dv_cf    [DIV_STAGES+1];
   logic        dv_last  [DIV_STAGES+1];
   logic [15:0] dv_thin  [DIV_STAGES+1];
   logic [15:0] dv_thick [DIV_STAGES+1];
   logic [15:0] dv_ts    [DIV_STAGES+1];
   logic [15:0] dv_rem   [DIV_STAGES+1];
   logic [15:0] dv_lo    [DIV_STAGES+1];
   logic        dv_sat   [DIV_STAGES+1];

   // Mean-conserving numerator, clamped at zero, plus half the divisor.
   logic [27:0] num_a;
   logic [31:0] num_sub;
   logic [27:0] num_c;
   logic [27:0] dividend;

   always_comb begin
      num_a    = {cf6_ff[15:0], 12'd0};
      num_sub  = 32'(thin6_ff) * 32'(ts6_ff);
      num_c    = (32'(num_a) > num_sub) ? num_a - num_sub[27:0] : 28'd0;
      dividend = num_c + 28'(thick6_ff >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) dv_v[0] <= 1'b0;
      else if (en) dv_v[0] <= v6_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         dv_cls[0]   <= cls6_ff;
         dv_cf[0]    <= cf6_ff;
         dv_last[0]  <= last6_ff;
         dv_thin[0]  <= thin6_ff;
         dv_thick[0] <= thick6_ff;
         dv_ts[0]    <= ts6_ff;
         dv_rem[0]   <= 16'(dividend[27:16]);
         dv_lo[0]    <= dividend[15:0];
         dv_sat[0]   <= 1'b0;
      end
   end

   for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
      logic [15:0] rem_in, lo_in;
      logic        sat_in;
      logic [16:0] trial;

      always_comb begin
         rem_in = dv_rem[s-1];
         lo_in  = dv_lo[s-1];
         trial  = 17'd0;
         // Overflow of the 16-bit quotient is known before the first step.
         sat_in = (s == 1) ? (dv_rem[s-1] >= dv_thick[s-1]) : dv_sat[s-1];
         for (int j = 0; j < DIV_STEPS; j++) begin
            trial = {rem_in, lo_in[15]};
            if (trial >= 17'(dv_thick[s-1])) begin
               rem_in = 16'(trial - 17'(dv_thick[s-1]));
               lo_in  = {lo_in[14:0], 1'b1};
            end else begin
               rem_in = trial[15:0];
               lo_in  = {lo_in[14:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) dv_v[s] <= 1'b0;
         else if (en) dv_v[s] <= dv_v[s-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dv_cls[s]   <= dv_cls[s-1];
            dv_cf[s]    <= dv_cf[s-1];
            dv_last[s]  <= dv_last[s-1];
            dv_thin[s]  <= dv_thin[s-1];
            dv_thick[s] <= dv_thick[s-1];
            dv_ts[s]    <= dv_ts[s-1];
            dv_rem[s]   <= rem_in;
            dv_lo[s]    <= lo_in;
            dv_sat[s]   <= sat_in;
         end
      end
   end

   // Output register: select the results by level class.
   logic [15:0] clr_ff, clr_in, thn_ff, thn_in, thk_ff, thk_in;
   logic [15:0] tsc_ff, tsc_in, ksc_ff, ksc_in;
   logic        lout_ff;

   always_comb begin
      case (dv_cls[DIV_STAGES])
         CLS_TWO: begin
            clr_in = ONE_Q15 - dv_cf[DIV_STAGES];
            thn_in = dv_cf[DIV_STAGES];
            thk_in = 16'd0;
            tsc_in = ONE_Q12;
            ksc_in = ONE_Q12;
         end
         CLS_SPLIT: begin
            clr_in = ONE_Q15 - dv_cf[DIV_STAGES];
            thn_in = dv_thin[DIV_STAGES];
            thk_in = dv_thick[DIV_STAGES];
            tsc_in = dv_ts[DIV_STAGES];
            ksc_in = dv_sat[DIV_STAGES] ? SAT_SCALING : dv_lo[DIV_STAGES];
         end
         default: begin
            clr_in = ONE_Q15;
            thn_in = 16'd0;
            thk_in = 16'd0;
            tsc_in = ONE_Q12;
            ksc_in = ONE_Q12;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) vout_ff <= 1'b0;
      else if (en) vout_ff <= dv_v[DIV_STAGES];
   end
   always_ff @(posedge clock) begin
      if (en) begin
         clr_ff  <= clr_in;
         thn_ff  <= thn_in;
         thk_ff  <= thk_in;
         tsc_ff  <= tsc_in;
         ksc_ff  <= ksc_in;
         lout_ff <= dv_last[DIV_STAGES];
      end
   end

   assign rsp_chan.valid          = vout_ff;
   assign rsp_chan.clear_fraction = clr_ff;
   assign rsp_chan.thin_fraction  = thn_ff;
   assign rsp_chan.thick_fraction = thk_ff;
   assign rsp_chan.thin_scaling   = tsc_ff;
   assign rsp_chan.thick_scaling  = ksc_ff;
   assign rsp_chan.last_out       = lout_ff;

endmodule

[rtl/core/crfs_checker.sv]
// Port-level checks of the cloud region scaling unit, bound to the top level.
// Depends on assert_macros.svh and the top level's channel ports.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module crfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] clear_fraction,
   input logic [15:0] thin_fraction,
   input logic [15:0] thick_fraction,
   input logic [15:0] thin_scaling,
   input logic [15:0] thick_scaling,
   input logic        last_out
);

   logic [16:0] frac_sum;
   logic [80:0] rsp_payload;
   assign frac_sum = 17'(clear_fraction) + 17'(thin_fraction) + 17'(thick_fraction);
   assign rsp_payload = {clear_fraction, thin_fraction, thick_fraction,
                         thin_scaling, thick_scaling, last_out};

   // A stalled result stays put until its transfer.
   `CRFS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // Input back-pressure only comes from a stalled output.
   `CRFS_ASSERT_IMP(a_ready_cause, clock, reset, !req_ready, rsp_valid && !rsp_ready)

   // The three regions always cover the whole level.
   `CRFS_ASSERT_IMP(a_frac_sum, clock, reset, rsp_valid, frac_sum == 17'd32768)

   // The thin region is never scaled above one.
   `CRFS_ASSERT_IMP(a_thin_scale, clock, reset, rsp_valid, thin_scaling <= 16'd4096)

endmodule

bind cloud_region_fraction_scaling_unit crfs_checker u_crfs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .clear_fraction (rsp_chan.clear_fraction),
   .thin_fraction  (rsp_chan.thin_fraction),
   .thick_fraction (rsp_chan.thick_fraction),
   .thin_scaling   (rsp_chan.thin_scaling),
   .thick_scaling  (rsp_chan.thick_scaling),
   .last_out       (rsp_chan.last_out)
);
